[rtl/core/i2ctrb_pkg.sv]
`timescale 1ns / 1ps

package i2ctrb_pkg;

   localparam int BANK_DEPTH_DEF = 256;
   localparam int BYTE_W         = 8;
   localparam int MODE_W         = 3;
   localparam int RSP_W          = 2;
   localparam int LEN_W          = 9;

   localparam logic [LEN_W-1:0] BANK_LEN_RESET = 9'd256;

   localparam logic [MODE_W-1:0] MODE_ADDR_WR  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADDR_RD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_STOP     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BYTE_RX  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BYTE_REQ = 3'd4;

   localparam logic [RSP_W-1:0] RSP_ACK  = 2'd0;
   localparam logic [RSP_W-1:0] RSP_NACK = 2'd1;
   localparam logic [RSP_W-1:0] RSP_NONE = 2'd2;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [BYTE_W-1:0] addr;
      logic [BYTE_W-1:0] wdata;
      logic [RSP_W-1:0]  rsp;
   } step_ctl_type;

endpackage

[rtl/core/i2ctrb_ram.sv]
`timescale 1ns / 1ps

module i2ctrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/i2ctrb_step.sv]
`timescale 1ns / 1ps

module i2ctrb_step
   import i2ctrb_pkg::*;
#(
   parameter int BANK_DEPTH = BANK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_go,
   input  logic [MODE_W-1:0] item_mode,
   input  logic              item_bus_error,
   input  logic [BYTE_W-1:0] item_data_in,
   input  logic [LEN_W-1:0]  bank_length,
   output step_ctl_type      ctl
);

   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_READ       = 3'd1;
   localparam logic [2:0] PH_WRITE      = 3'd2;
   localparam logic [2:0] PH_WADDR      = 3'd3;
   localparam logic [2:0] PH_WADDR_DONE = 3'd4;

   localparam logic [LEN_W-1:0] DEPTH_LIM = LEN_W'(BANK_DEPTH);

   logic [2:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] pointer_ff, pointer_in;
   logic [LEN_W-1:0]  limit;
   logic              in_range;
   logic              wr_hit, rd_hit;
   logic [RSP_W-1:0]  rsp;

   assign limit    = (bank_length > DEPTH_LIM) ? DEPTH_LIM : bank_length;
   assign in_range = {1'b0, pointer_ff} < limit;

   always_comb begin
      phase_in   = phase_ff;
      pointer_in = pointer_ff;
      rsp        = RSP_NACK;
      wr_hit     = 1'b0;
      rd_hit     = 1'b0;
      unique case (item_mode)
         MODE_ADDR_WR: begin
            if (item_bus_error) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_WADDR;
               rsp      = RSP_ACK;
            end
         end
         MODE_ADDR_RD: begin
            if (item_bus_error) begin
               phase_in = PH_IDLE;
            end else if (phase_ff == PH_READ || phase_ff == PH_WADDR_DONE) begin
               phase_in = PH_READ;
               rsp      = RSP_ACK;
            end
         end
         MODE_STOP: begin
            rsp = RSP_NONE;
         end
         MODE_BYTE_RX: begin
            if (phase_ff == PH_WADDR) begin
               pointer_in = item_data_in;
               phase_in   = PH_WADDR_DONE;
               rsp        = RSP_ACK;
            end else if (phase_ff == PH_WADDR_DONE || phase_ff == PH_WRITE) begin
               phase_in = PH_WRITE;
               if (in_range) begin
                  wr_hit     = 1'b1;
                  pointer_in = pointer_ff + 8'd1;
                  rsp        = RSP_ACK;
               end
            end
         end
         MODE_BYTE_REQ: begin
            if (phase_ff == PH_READ && in_range) begin
               rd_hit     = 1'b1;
               pointer_in = pointer_ff + 8'd1;
               rsp        = RSP_ACK;
            end
         end
         default: begin
            rsp = RSP_NACK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pointer_ff <= '0;
      end else if (item_go) begin
         phase_ff   <= phase_in;
         pointer_ff <= pointer_in;
      end
   end

   assign ctl.wr_en = item_go && wr_hit;
   assign ctl.rd_en = item_go && rd_hit;
   assign ctl.addr  = pointer_ff;
   assign ctl.wdata = item_data_in;
   assign ctl.rsp   = rsp;

endmodule

[rtl/core/i2c_target_register_bank.sv]
`timescale 1ns / 1ps
// An accepted request transaction moves through the s1 stage, the s2 stage and the result registers to its result.
// Throughput: one transaction per cycle while the result side does not stall.
// The pipeline advances as a whole; rsp_stall on a held result freezes every stage.
// Reset (synchronous): phase idle, pointer 0, bank length 256, all entry valid
// bits cleared so every register reads as zero until written; req_stall held high.

module i2c_target_register_bank
   import i2ctrb_pkg::*;
#(
   parameter int BANK_DEPTH = BANK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [MODE_W-1:0] req_mode,
   input  logic              req_bus_error,
   input  logic [BYTE_W-1:0] req_data_in,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [RSP_W-1:0]  rsp_response,
   output logic [BYTE_W-1:0] rsp_data_out
);

   localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic [LEN_W-1:0]  bank_length_ff;
   logic              advance;

   logic              s1_valid_ff;
   logic [MODE_W-1:0] s1_mode_ff;
   logic              s1_bus_error_ff;
   logic [BYTE_W-1:0] s1_data_ff;

   step_ctl_type      ctl;
   logic [AW-1:0]     idx;
   logic [BANK_DEPTH-1:0] vld_ff;

   logic              s2_valid_ff;
   logic [RSP_W-1:0]  s2_rsp_ff;
   logic              s2_rd_ff;
   logic              s2_vld_ff;
   logic [BYTE_W-1:0] ram_q;

   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_response_ff;
   logic [BYTE_W-1:0] rsp_data_out_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_length_ff <= BANK_LEN_RESET;
      end else if (csr_wr_en) begin
         bank_length_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mode_ff      <= req_mode;
         s1_bus_error_ff <= req_bus_error;
         s1_data_ff      <= req_data_in;
      end
   end

   i2ctrb_step #(
      .BANK_DEPTH (BANK_DEPTH)
   ) u_step (
      .clock          (clock),
      .reset          (reset),
      .item_go        (advance && s1_valid_ff),
      .item_mode      (s1_mode_ff),
      .item_bus_error (s1_bus_error_ff),
      .item_data_in   (s1_data_ff),
      .bank_length    (bank_length_ff),
      .ctl            (ctl)
   );

   assign idx = ctl.addr[AW-1:0];

   i2ctrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (idx),
      .wr_data (ctl.wdata),
      .rd_en   (ctl.rd_en),
      .rd_addr (idx),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.wr_en) begin
         vld_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_rsp_ff <= ctl.rsp;
         s2_rd_ff  <= ctl.rd_en;
         s2_vld_ff <= ctl.rd_en && vld_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_response_ff <= s2_rsp_ff;
         rsp_data_out_ff <= (s2_rd_ff && s2_vld_ff) ? ram_q : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_response = rsp_response_ff;
   assign rsp_data_out = rsp_data_out_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_out_ff != '0 |-> rsp_response_ff == RSP_ACK)
      else $error("nonzero data on a result that is not an ack");

   assert property (@(posedge clock) disable iff (reset)
      !(ctl.wr_en && ctl.rd_en))
      else $error("bank write and read issued for one transaction");

   assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |=> vld_ff[$past(idx)])
      else $error("written entry not marked valid");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_response_ff == RSP_ACK || rsp_response_ff == RSP_NACK ||
                        rsp_response_ff == RSP_NONE))
      else $error("undefined response code");

endmodule
